// ===== rtl/sctc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sctc_pkg
// Types, codes and constants shared by the temperature controller modules.
// ----------------------------------------------------------------------------
package sctc_pkg;

  // input item codes
  localparam logic [1:0] CMD_BYTE = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_ADC  = 2'd2;

  // result kinds
  localparam logic KIND_REPLY = 1'b0;
  localparam logic KIND_DRIVE = 1'b1;

  // frame header bytes
  localparam logic [7:0] HDR_C = 8'h43;
  localparam logic [7:0] HDR_O = 8'h4F;
  localparam logic [7:0] HDR_M = 8'h4D;

  // opcodes
  localparam logic [7:0] OP_MODE1  = 8'hA0;
  localparam logic [7:0] OP_MODE2  = 8'hA1;
  localparam logic [7:0] OP_MODE3  = 8'hA2;
  localparam logic [7:0] OP_TOGGLE = 8'hA3;
  localparam logic [7:0] OP_START  = 8'hA4;
  localparam logic [7:0] OP_STOP   = 8'hA5;
  localparam logic [7:0] OP_TEMP   = 8'hA8;
  localparam logic [7:0] OP_RDSTRT = 8'hAA;
  localparam logic [7:0] OP_RDSTOP = 8'hAB;
  localparam logic [7:0] OP_STATUS = 8'hAE;

  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_FULL = 8'hFF;

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_SET  = 2'd1;
  localparam logic [1:0] MODE_UP   = 2'd2;
  localparam logic [1:0] MODE_DOWN = 2'd3;

  localparam logic [7:0] SEC_RELOAD = 8'd60;

  // status bit masks
  localparam logic [7:0] ST_ENABLE = 8'h80;
  localparam logic [7:0] ST_START  = 8'h40;
  localparam logic [7:0] ST_STOP   = 8'h20;

  // reply framing
  localparam int unsigned REPLY_LEN = 6;
  localparam int unsigned IDX_W     = $clog2(REPLY_LEN);
  localparam logic [IDX_W-1:0] IDX_HC   = IDX_W'(0);
  localparam logic [IDX_W-1:0] IDX_HO   = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_HM   = IDX_W'(2);
  localparam logic [IDX_W-1:0] IDX_OP   = IDX_W'(3);
  localparam logic [IDX_W-1:0] IDX_B4   = IDX_W'(4);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(REPLY_LEN - 1);

  // job queue between front and back
  localparam int unsigned JOB_DEPTH = 4;
  localparam int unsigned JOB_AW    = $clog2(JOB_DEPTH);

  typedef enum logic [2:0] {
    PH_C  = 3'd0,
    PH_O  = 3'd1,
    PH_M  = 3'd2,
    PH_OP = 3'd3,
    PH_P1 = 3'd4,
    PH_P2 = 3'd5
  } phase_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] value;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic       drive;
    logic [7:0] op;
    logic [7:0] b4;
    logic [7:0] b5;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

// ===== rtl/sctc_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sctc_queue
// Short job queue that decouples the command front from the output back.
// ----------------------------------------------------------------------------
module sctc_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire sctc_pkg::job_t   wr_job,
  input  wire logic             pop,
  output sctc_pkg::job_t        head,
  output sctc_pkg::q_status_t   status
);

  sctc_pkg::job_t mem [sctc_pkg::JOB_DEPTH];
  logic [sctc_pkg::JOB_AW-1:0] wr_ptr;
  logic [sctc_pkg::JOB_AW-1:0] rd_ptr;
  logic [sctc_pkg::JOB_AW:0]   count;

  logic do_push;
  logic do_pop;

  assign status.full  = (count == (sctc_pkg::JOB_AW + 1)'(sctc_pkg::JOB_DEPTH));
  assign status.empty = (count == '0);
  assign do_push = push && !status.full;
  assign do_pop  = pop && !status.empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (sctc_pkg::JOB_AW + 1)'(do_push) - (sctc_pkg::JOB_AW + 1)'(do_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (sctc_pkg::JOB_AW + 1)'(sctc_pkg::JOB_DEPTH))
    else $error("job queue count above depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(push && status.full))
    else $error("job pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !(pop && status.empty))
    else $error("job popped from an empty queue");

endmodule
`default_nettype wire

// ===== rtl/sctc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sctc_front
// Takes input items, parses command frames, runs countdowns and the heater
// comparison, and hands reply or drive jobs to the queue.
// ----------------------------------------------------------------------------
module sctc_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire sctc_pkg::in_item_t item,
  output logic                    job_push,
  output sctc_pkg::job_t          job
);

  sctc_pkg::phase_t phase, phase_next;
  logic [7:0]  opcode_byte, opcode_byte_next;
  logic [7:0]  param_one, param_one_next;
  logic        control_enable, control_enable_next;
  logic [1:0]  control_mode, control_mode_next;
  logic [7:0]  reported_temp, reported_temp_next;
  logic [6:0]  latest_temp, latest_temp_next;
  logic [7:0]  start_minutes, start_minutes_next;
  logic [7:0]  start_seconds, start_seconds_next;
  logic [7:0]  stop_minutes, stop_minutes_next;
  logic [7:0]  stop_seconds, stop_seconds_next;
  logic [15:0] tick_count, tick_count_next;
  logic        start_pending, start_pending_next;
  logic        stop_pending, stop_pending_next;
  logic [7:0]  status_bits, status_bits_next;

  logic        is_byte;
  logic [13:0] min_ticks;
  logic [15:0] ticks;
  logic [14:0] prod;
  logic [6:0]  temp;
  logic signed [9:0] target;
  logic signed [9:0] temp_s;
  logic [7:0]  status_now;

  assign is_byte   = accept && (item.cmd == sctc_pkg::CMD_BYTE);
  assign min_ticks = 14'(param_one) * 14'd60;
  assign ticks     = {15'(min_ticks) + 15'(item.data), 1'b0};

  // scale to 0..100 with round half up
  assign prod   = 15'(item.data) * 15'd100;
  assign temp   = 7'(prod[14:8]) + 7'(prod[7]);
  assign temp_s = 10'(temp);
  assign status_now = status_bits
                    | (control_enable ? sctc_pkg::ST_ENABLE : 8'h00)
                    | (start_pending  ? sctc_pkg::ST_START  : 8'h00)
                    | (stop_pending   ? sctc_pkg::ST_STOP   : 8'h00);

  always_comb begin
    case (control_mode)
      sctc_pkg::MODE_SET:  target = 10'(param_one);
      sctc_pkg::MODE_UP:   target = 10'(reported_temp) + 10'sd1;
      sctc_pkg::MODE_DOWN: target = 10'(reported_temp) - 10'sd1;
      default:             target = 10'sd0;
    endcase
  end

  // frame phase
  always_comb begin
    phase_next = phase;
    if (is_byte) begin
      case (phase)
        sctc_pkg::PH_O:  phase_next = (item.data == sctc_pkg::HDR_O) ? sctc_pkg::PH_M
                                                                     : sctc_pkg::PH_C;
        sctc_pkg::PH_M:  phase_next = (item.data == sctc_pkg::HDR_M) ? sctc_pkg::PH_OP
                                                                     : sctc_pkg::PH_C;
        sctc_pkg::PH_OP: phase_next = sctc_pkg::PH_P1;
        sctc_pkg::PH_P1: phase_next = sctc_pkg::PH_P2;
        sctc_pkg::PH_P2: phase_next = sctc_pkg::PH_C;
        default:         phase_next = (item.data == sctc_pkg::HDR_C) ? sctc_pkg::PH_O
                                                                     : sctc_pkg::PH_C;
      endcase
    end
  end

  // datapath and job generation
  always_comb begin
    opcode_byte_next    = opcode_byte;
    param_one_next      = param_one;
    control_enable_next = control_enable;
    control_mode_next   = control_mode;
    reported_temp_next  = reported_temp;
    latest_temp_next    = latest_temp;
    start_minutes_next  = start_minutes;
    start_seconds_next  = start_seconds;
    stop_minutes_next   = stop_minutes;
    stop_seconds_next   = stop_seconds;
    tick_count_next     = tick_count;
    start_pending_next  = start_pending;
    stop_pending_next   = stop_pending;
    status_bits_next    = status_bits;
    job_push            = 1'b0;
    job.drive           = 1'b0;
    job.op              = opcode_byte;
    job.b4              = sctc_pkg::BYTE_ZERO;
    job.b5              = sctc_pkg::BYTE_ZERO;

    if (accept) begin
      case (item.cmd)
        sctc_pkg::CMD_BYTE: begin
          if (phase == sctc_pkg::PH_OP) begin
            opcode_byte_next = item.data;
          end else if (phase == sctc_pkg::PH_P1) begin
            param_one_next = item.data;
          end else if (phase == sctc_pkg::PH_P2) begin
            case (opcode_byte)
              sctc_pkg::OP_MODE1: begin
                control_enable_next = 1'b1;
                control_mode_next   = sctc_pkg::MODE_SET;
              end
              sctc_pkg::OP_MODE2: begin
                control_enable_next = 1'b1;
                control_mode_next   = sctc_pkg::MODE_UP;
              end
              sctc_pkg::OP_MODE3: begin
                control_enable_next = 1'b1;
                control_mode_next   = sctc_pkg::MODE_DOWN;
              end
              sctc_pkg::OP_TOGGLE: begin
                control_enable_next = !control_enable;
              end
              sctc_pkg::OP_START: begin
                start_pending_next  = 1'b1;
                control_enable_next = 1'b0;
                start_minutes_next  = param_one;
                start_seconds_next  = item.data;
                tick_count_next     = ticks;
              end
              sctc_pkg::OP_STOP: begin
                stop_pending_next   = 1'b1;
                control_enable_next = 1'b1;
                stop_minutes_next   = param_one;
                stop_seconds_next   = item.data;
                tick_count_next     = ticks;
              end
              sctc_pkg::OP_TEMP: begin
                reported_temp_next = 8'(latest_temp);
                job_push = 1'b1;
                job.b4   = 8'(latest_temp);
                job.b5   = sctc_pkg::BYTE_ZERO;
              end
              sctc_pkg::OP_RDSTRT: begin
                job_push = 1'b1;
                job.b4   = start_minutes;
                job.b5   = start_seconds;
              end
              sctc_pkg::OP_RDSTOP: begin
                job_push = 1'b1;
                job.b4   = stop_minutes;
                job.b5   = stop_seconds;
              end
              sctc_pkg::OP_STATUS: begin
                status_bits_next = status_now;
                job_push = 1'b1;
                job.b4   = status_now;
                job.b5   = sctc_pkg::BYTE_FULL;
              end
              default: begin
              end
            endcase
          end
        end
        sctc_pkg::CMD_TICK: begin
          // start countdown first, the stop countdown sees its tick count
          if (start_pending) begin
            if (tick_count != 16'd0) begin
              tick_count_next = tick_count - 16'd1;
              if (start_seconds == 8'd0) begin
                start_seconds_next = sctc_pkg::SEC_RELOAD;
                start_minutes_next = start_minutes - 8'd1;
              end else begin
                start_seconds_next = start_seconds - 8'd1;
              end
            end else begin
              control_enable_next = 1'b1;
              start_pending_next  = 1'b0;
            end
          end
          if (stop_pending) begin
            if (tick_count_next != 16'd0) begin
              tick_count_next = tick_count_next - 16'd1;
              if (stop_seconds == 8'd0) begin
                stop_seconds_next = sctc_pkg::SEC_RELOAD;
                stop_minutes_next = stop_minutes - 8'd1;
              end else begin
                stop_seconds_next = stop_seconds - 8'd1;
              end
            end else begin
              control_enable_next = 1'b0;
              stop_pending_next   = 1'b0;
            end
          end
        end
        sctc_pkg::CMD_ADC: begin
          latest_temp_next = temp;
          if (control_enable && (control_mode != sctc_pkg::MODE_NONE) &&
              (target != temp_s)) begin
            job_push  = 1'b1;
            job.drive = 1'b1;
            job.b4    = (target > temp_s) ? sctc_pkg::BYTE_FULL : sctc_pkg::BYTE_ZERO;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= sctc_pkg::PH_C;
      opcode_byte    <= '0;
      param_one      <= '0;
      control_enable <= 1'b0;
      control_mode   <= sctc_pkg::MODE_NONE;
      reported_temp  <= '0;
      latest_temp    <= '0;
      start_minutes  <= '0;
      start_seconds  <= '0;
      stop_minutes   <= '0;
      stop_seconds   <= '0;
      tick_count     <= '0;
      start_pending  <= 1'b0;
      stop_pending   <= 1'b0;
      status_bits    <= '0;
    end else begin
      phase          <= phase_next;
      opcode_byte    <= opcode_byte_next;
      param_one      <= param_one_next;
      control_enable <= control_enable_next;
      control_mode   <= control_mode_next;
      reported_temp  <= reported_temp_next;
      latest_temp    <= latest_temp_next;
      start_minutes  <= start_minutes_next;
      start_seconds  <= start_seconds_next;
      stop_minutes   <= stop_minutes_next;
      stop_seconds   <= stop_seconds_next;
      tick_count     <= tick_count_next;
      start_pending  <= start_pending_next;
      stop_pending   <= stop_pending_next;
      status_bits    <= status_bits_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sctc_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sctc_back
// Turns queued jobs into result beats: six reply bytes or one drive update,
// held in an output register until taken.
// ----------------------------------------------------------------------------
module sctc_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire sctc_pkg::job_t      head,
  input  wire sctc_pkg::q_status_t q_status,
  output logic                     job_pop,
  input  wire logic                pop,
  output logic                     empty,
  output sctc_pkg::out_item_t      result
);

  logic                       out_valid;
  logic [sctc_pkg::IDX_W-1:0] idx;
  logic                       load;
  logic                       beat_last;
  sctc_pkg::out_item_t        beat;

  assign empty     = !out_valid;
  assign load      = !q_status.empty && (!out_valid || pop);
  assign beat_last = head.drive || (idx == sctc_pkg::IDX_LAST);
  assign job_pop   = load && beat_last;

  always_comb begin
    beat.last = beat_last;
    if (head.drive) begin
      beat.kind  = sctc_pkg::KIND_DRIVE;
      beat.value = head.b4;
    end else begin
      beat.kind = sctc_pkg::KIND_REPLY;
      case (idx)
        sctc_pkg::IDX_HC: beat.value = sctc_pkg::HDR_C;
        sctc_pkg::IDX_HO: beat.value = sctc_pkg::HDR_O;
        sctc_pkg::IDX_HM: beat.value = sctc_pkg::HDR_M;
        sctc_pkg::IDX_OP: beat.value = head.op;
        sctc_pkg::IDX_B4: beat.value = head.b4;
        default:          beat.value = head.b5;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= beat_last ? '0 : idx + 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= sctc_pkg::IDX_LAST)
    else $error("reply byte index out of range");

  // a reply in progress keeps its job at the queue head
  a_idx_has_job: assert property (@(posedge clk) disable iff (rst)
    (idx != '0) |-> !q_status.empty)
    else $error("reply in progress without a queued job");

  a_drive_last: assert property (@(posedge clk) disable iff (rst)
    (load && head.drive) |=> (result.last && result.kind == sctc_pkg::KIND_DRIVE))
    else $error("drive update not marked last");

endmodule
`default_nettype wire

// ===== rtl/serial_command_temperature_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// serial_command_temperature_controller
// Serial command parser, countdown timers and bang-bang heater control.
//
//   channel  handshake         payload
//   -------  ----------------  -------------------------------
//   item     push / full       in_item_t  {cmd, data}
//   result   pop / empty       out_item_t {kind, value, last}
//
// An item is taken every cycle while the job queue has room; the front
// handles each item in the cycle it is taken. The back sends one beat per
// cycle from the output register while results are popped, so a reply is
// six beats and a drive update one; replies bound the sustained command rate.
// Reset is synchronous and clears all control state; there is no clearing
// pass. A stalled result side fills the 4-entry job queue, then raises full.
// ----------------------------------------------------------------------------
module serial_command_temperature_controller (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  output logic                     full,
  input  wire sctc_pkg::in_item_t  item,
  input  wire logic                pop,
  output logic                     empty,
  output sctc_pkg::out_item_t      result
);

  logic                accept;
  logic                job_push;
  logic                job_pop;
  sctc_pkg::job_t      job;
  sctc_pkg::job_t      head;
  sctc_pkg::q_status_t q_status;

  assign full   = q_status.full;
  assign accept = push && !q_status.full;

  sctc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .job_push (job_push),
    .job      (job)
  );

  sctc_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (job_push),
    .wr_job (job),
    .pop    (job_pop),
    .head   (head),
    .status (q_status)
  );

  sctc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .job_pop  (job_pop),
    .pop      (pop),
    .empty    (empty),
    .result   (result)
  );

endmodule
`default_nettype wire
